FILE: rtl/core/zsep_pkg.sv
`default_nettype none

package zsep_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       name_end;
        logic       accept;
        logic       data_end;
        logic       status;
        logic       entry_cut;
        logic       last;
    } out_item_t;

    // One queue entry holds everything a single input byte caused:
    // an optional name or data byte and an optional end report.
    typedef struct packed {
        logic       has_byte;
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       name_end;
        logic       accept;
        logic       data_end;
        logic       has_report;
        logic       status;
        logic       entry_cut;
    } queue_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/zip_stored_entry_parser.sv
`default_nettype none

// Streaming parser for the local entries of a stored ZIP archive, one archive byte per
// request on the s_ side. The front end hunts for the local header signature, reads the
// 30-byte header and tracks the name, extra and data regions as each byte is accepted;
// it writes what each byte produces into a small queue, and the back end drains that queue
// into a registered m_ side, one result per cycle while m_ready allows. Sustained rate is
// one byte per cycle while the queue has room; a byte with end_of_stream that also yields
// a name or data byte produces two results, the byte and the end report, which the queue
// absorbs. Each result is queued as its byte is accepted, then registered onto the m_ side.
// After the end report the parser is back in its reset state, ready for the next archive.
module zip_stored_entry_parser #(
    parameter int QUEUE_DEPTH = zsep_pkg::QUEUE_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire zsep_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output zsep_pkg::out_item_t      m_data
);
    import zsep_pkg::*;

    logic         q_push, q_full, q_pop, q_empty;
    queue_entry_t q_wdata, q_rdata;

    zsep_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    zsep_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    zsep_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/zsep_front.sv
`default_nettype none

module zsep_front (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire zsep_pkg::in_item_t     s_data,
    input  wire logic                   q_full,
    output logic                        q_push,
    output zsep_pkg::queue_entry_t      q_data
);
    import zsep_pkg::*;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_NAME   = 3'd2;
    localparam logic [2:0] PH_EXTRA  = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;

    localparam logic [7:0] SIG_0 = 8'h50;
    localparam logic [7:0] SIG_1 = 8'h4B;
    localparam logic [7:0] SIG_2 = 8'h03;
    localparam logic [7:0] SIG_3 = 8'h04;
    localparam logic [7:0] SLASH = 8'h2F;

    localparam logic [4:0] HDR_FIRST   = 5'd4;
    localparam logic [4:0] HDR_LAST    = 5'd29;
    localparam logic [4:0] MIN_ARCHIVE = 5'd22;

    localparam logic [4:0] OFS_METHOD_LO = 5'd8;
    localparam logic [4:0] OFS_METHOD_HI = 5'd9;
    localparam logic [4:0] OFS_PACKED_0  = 5'd18;
    localparam logic [4:0] OFS_PACKED_1  = 5'd19;
    localparam logic [4:0] OFS_PACKED_2  = 5'd20;
    localparam logic [4:0] OFS_PACKED_3  = 5'd21;
    localparam logic [4:0] OFS_PLAIN_0   = 5'd22;
    localparam logic [4:0] OFS_PLAIN_1   = 5'd23;
    localparam logic [4:0] OFS_PLAIN_2   = 5'd24;
    localparam logic [4:0] OFS_PLAIN_3   = 5'd25;
    localparam logic [4:0] OFS_NAME_LO   = 5'd26;
    localparam logic [4:0] OFS_NAME_HI   = 5'd27;
    localparam logic [4:0] OFS_EXTRA_LO  = 5'd28;
    localparam logic [4:0] OFS_EXTRA_HI  = 5'd29;

    logic [2:0]  phase_reg,          phase_next;
    logic [1:0]  sig_matched_reg,    sig_matched_next;
    logic [4:0]  header_index_reg,   header_index_next;
    logic [15:0] method_code_reg,    method_code_next;
    logic [31:0] packed_size_reg,    packed_size_next;
    logic [31:0] plain_size_reg,     plain_size_next;
    logic [15:0] name_length_reg,    name_length_next;
    logic [15:0] extra_length_reg,   extra_length_next;
    logic [31:0] remaining_reg,      remaining_next;
    logic [4:0]  byte_total_reg,     byte_total_next;
    logic        entry_accepted_reg, entry_accepted_next;

    logic        take;
    logic [7:0]  b;
    logic [7:0]  sig_expected;
    logic [31:0] rem_dec;
    logic [15:0] extra_full;
    logic        name_ok;

    assign s_ready = !q_full;
    assign take    = s_valid && !q_full;
    assign b       = s_data.in_byte;
    assign rem_dec = remaining_reg - 32'd1;

    always_comb begin
        case (sig_matched_reg)
            2'd0:    sig_expected = SIG_0;
            2'd1:    sig_expected = SIG_1;
            2'd2:    sig_expected = SIG_2;
            default: sig_expected = SIG_3;
        endcase
    end

    always_comb begin
        phase_next          = phase_reg;
        sig_matched_next    = sig_matched_reg;
        header_index_next   = header_index_reg;
        method_code_next    = method_code_reg;
        packed_size_next    = packed_size_reg;
        plain_size_next     = plain_size_reg;
        name_length_next    = name_length_reg;
        extra_length_next   = extra_length_reg;
        remaining_next      = remaining_reg;
        entry_accepted_next = entry_accepted_reg;
        byte_total_next     = (byte_total_reg < MIN_ARCHIVE) ?
                              byte_total_reg + 5'd1 : byte_total_reg;
        extra_full          = {b, extra_length_reg[7:0]};
        name_ok             = 1'b0;
        q_data              = '0;

        case (phase_reg)
            PH_HUNT: begin
                if (b == sig_expected) begin
                    if (sig_matched_reg == 2'd3) begin
                        phase_next          = PH_HEADER;
                        header_index_next   = HDR_FIRST;
                        sig_matched_next    = 2'd0;
                        method_code_next    = '0;
                        packed_size_next    = '0;
                        plain_size_next     = '0;
                        name_length_next    = '0;
                        extra_length_next   = '0;
                        entry_accepted_next = 1'b0;
                    end else begin
                        sig_matched_next = sig_matched_reg + 2'd1;
                    end
                end else begin
                    sig_matched_next = (b == SIG_0) ? 2'd1 : 2'd0;
                end
            end
            PH_HEADER: begin
                case (header_index_reg)
                    OFS_METHOD_LO: method_code_next[7:0]   = b;
                    OFS_METHOD_HI: method_code_next[15:8]  = b;
                    OFS_PACKED_0:  packed_size_next[7:0]   = b;
                    OFS_PACKED_1:  packed_size_next[15:8]  = b;
                    OFS_PACKED_2:  packed_size_next[23:16] = b;
                    OFS_PACKED_3:  packed_size_next[31:24] = b;
                    OFS_PLAIN_0:   plain_size_next[7:0]    = b;
                    OFS_PLAIN_1:   plain_size_next[15:8]   = b;
                    OFS_PLAIN_2:   plain_size_next[23:16]  = b;
                    OFS_PLAIN_3:   plain_size_next[31:24]  = b;
                    OFS_NAME_LO:   name_length_next[7:0]   = b;
                    OFS_NAME_HI:   name_length_next[15:8]  = b;
                    OFS_EXTRA_LO:  extra_length_next[7:0]  = b;
                    OFS_EXTRA_HI:  extra_length_next[15:8] = b;
                    default: ;
                endcase
                if (header_index_reg >= HDR_LAST) begin
                    header_index_next   = '0;
                    entry_accepted_next = 1'b0;
                    if (name_length_reg != 16'd0) begin
                        phase_next     = PH_NAME;
                        remaining_next = {16'd0, name_length_reg};
                    end else if (extra_full != 16'd0) begin
                        phase_next     = PH_EXTRA;
                        remaining_next = {16'd0, extra_full};
                    end else if (packed_size_reg != 32'd0) begin
                        phase_next     = PH_DATA;
                        remaining_next = packed_size_reg;
                    end else begin
                        phase_next       = PH_HUNT;
                        sig_matched_next = 2'd0;
                    end
                end else begin
                    header_index_next = header_index_reg + 5'd1;
                end
            end
            PH_NAME: begin
                remaining_next   = rem_dec;
                q_data.has_byte  = 1'b1;
                q_data.kind      = KIND_NAME;
                q_data.out_byte  = b;
                if (rem_dec == 32'd0) begin
                    name_ok = (method_code_reg == 16'd0) &&
                              (packed_size_reg == plain_size_reg) && (b != SLASH);
                    q_data.name_end     = 1'b1;
                    q_data.accept       = name_ok;
                    entry_accepted_next = name_ok;
                    if (extra_length_reg != 16'd0) begin
                        phase_next     = PH_EXTRA;
                        remaining_next = {16'd0, extra_length_reg};
                    end else if (packed_size_reg != 32'd0) begin
                        phase_next     = PH_DATA;
                        remaining_next = packed_size_reg;
                    end else begin
                        phase_next       = PH_HUNT;
                        sig_matched_next = 2'd0;
                    end
                end
            end
            PH_EXTRA: begin
                remaining_next = rem_dec;
                if (rem_dec == 32'd0) begin
                    if (packed_size_reg != 32'd0) begin
                        phase_next     = PH_DATA;
                        remaining_next = packed_size_reg;
                    end else begin
                        phase_next       = PH_HUNT;
                        sig_matched_next = 2'd0;
                    end
                end
            end
            default: begin
                remaining_next = rem_dec;
                if (entry_accepted_reg) begin
                    q_data.has_byte = 1'b1;
                    q_data.kind     = KIND_DATA;
                    q_data.out_byte = b;
                    q_data.data_end = (rem_dec == 32'd0);
                end
                if (rem_dec == 32'd0) begin
                    phase_next          = PH_HUNT;
                    sig_matched_next    = 2'd0;
                    entry_accepted_next = 1'b0;
                end
            end
        endcase

        if (s_data.end_of_stream) begin
            q_data.has_report   = 1'b1;
            q_data.status       = (byte_total_next < MIN_ARCHIVE);
            q_data.entry_cut    = (phase_next != PH_HUNT);
            phase_next          = PH_HUNT;
            sig_matched_next    = '0;
            header_index_next   = '0;
            method_code_next    = '0;
            packed_size_next    = '0;
            plain_size_next     = '0;
            name_length_next    = '0;
            extra_length_next   = '0;
            remaining_next      = '0;
            byte_total_next     = '0;
            entry_accepted_next = 1'b0;
        end
    end

    assign q_push = take && (q_data.has_byte || q_data.has_report);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_HUNT;
            sig_matched_reg    <= '0;
            header_index_reg   <= '0;
            method_code_reg    <= '0;
            packed_size_reg    <= '0;
            plain_size_reg     <= '0;
            name_length_reg    <= '0;
            extra_length_reg   <= '0;
            remaining_reg      <= '0;
            byte_total_reg     <= '0;
            entry_accepted_reg <= 1'b0;
        end else if (take) begin
            phase_reg          <= phase_next;
            sig_matched_reg    <= sig_matched_next;
            header_index_reg   <= header_index_next;
            method_code_reg    <= method_code_next;
            packed_size_reg    <= packed_size_next;
            plain_size_reg     <= plain_size_next;
            name_length_reg    <= name_length_next;
            extra_length_reg   <= extra_length_next;
            remaining_reg      <= remaining_next;
            byte_total_reg     <= byte_total_next;
            entry_accepted_reg <= entry_accepted_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/zsep_fifo.sv
`default_nettype none

module zsep_fifo #(
    parameter int DEPTH = zsep_pkg::QUEUE_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire zsep_pkg::queue_entry_t push_data,
    output logic                        full,
    input  wire logic                   pop,
    output zsep_pkg::queue_entry_t      pop_data,
    output logic                        empty
);
    import zsep_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    queue_entry_t  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/zsep_back.sv
`default_nettype none

module zsep_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_empty,
    input  wire zsep_pkg::queue_entry_t q_data,
    output logic                        q_pop,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output zsep_pkg::out_item_t         m_data
);
    import zsep_pkg::*;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg,  m_data_next;
    logic      pend_reg,    pend_next;
    logic      pend_status_reg, pend_status_next;
    logic      pend_cut_reg,    pend_cut_next;
    logic      out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = out_free && !pend_reg && !q_empty;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        pend_next        = pend_reg;
        pend_status_next = pend_status_reg;
        pend_cut_next    = pend_cut_reg;

        if (out_free) begin
            m_valid_next = 1'b0;
            if (pend_reg) begin
                m_valid_next          = 1'b1;
                m_data_next           = '0;
                m_data_next.kind      = KIND_REPORT;
                m_data_next.status    = pend_status_reg;
                m_data_next.entry_cut = pend_cut_reg;
                m_data_next.last      = 1'b1;
                pend_next             = 1'b0;
            end else if (!q_empty) begin
                m_valid_next = 1'b1;
                m_data_next  = '0;
                if (q_data.has_byte) begin
                    m_data_next.kind     = q_data.kind;
                    m_data_next.out_byte = q_data.out_byte;
                    m_data_next.name_end = q_data.name_end;
                    m_data_next.accept   = q_data.accept;
                    m_data_next.data_end = q_data.data_end;
                    m_data_next.last     = !q_data.has_report;
                    pend_next            = q_data.has_report;
                    pend_status_next     = q_data.status;
                    pend_cut_next        = q_data.entry_cut;
                end else begin
                    m_data_next.kind      = KIND_REPORT;
                    m_data_next.status    = q_data.status;
                    m_data_next.entry_cut = q_data.entry_cut;
                    m_data_next.last      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg      <= m_data_next;
        pend_status_reg <= pend_status_next;
        pend_cut_reg    <= pend_cut_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

`default_nettype wire
